[rtl/core/strided_tensor_slice_assert.svh]
// ----------------------------------------------------------------------------
// strided_tensor_slice assertion macros
// shared concurrent assertion forms for the slice checker
// ----------------------------------------------------------------------------
`ifndef STRIDED_TENSOR_SLICE_ASSERT_SVH
`define STRIDED_TENSOR_SLICE_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define STS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is held
`define STS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, constants and helpers of the strided tensor slice
// ----------------------------------------------------------------------------
package sts_pkg;

    // default limits
    localparam int MAX_SIDE_DEF   = 4096;
    localparam int MAX_PLANES_DEF = 4096;
    localparam int DATA_BITS_DEF  = 32;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int START_W   = 12;
    localparam int IDX_W     = 12;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_START_COL  = 3'd2,
        REG_STEP_COL   = 3'd3,
        REG_START_ROW  = 3'd4,
        REG_STEP_ROW   = 3'd5,
        REG_START_CHAN = 3'd6,
        REG_STEP_CHAN  = 3'd7
    } t_reg_idx;

    // per-axis counter control
    typedef struct packed {
        logic en;    // axis moves on by one position
        logic wrap;  // axis returns to zero instead of moving on
        logic clr;   // whole tensor ends, every counter returns to zero
    } t_axis_ctl;

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

[rtl/core/sts_cfg.sv]
// ----------------------------------------------------------------------------
// sts_cfg
// configuration registers with size and step limiting
// ----------------------------------------------------------------------------
module sts_cfg #(
    parameter int MAX_SIDE   = sts_pkg::MAX_SIDE_DEF,
    parameter int MAX_PLANES = sts_pkg::MAX_PLANES_DEF,
    parameter int SIDE_SZ_W  = $clog2(MAX_SIDE + 1),
    parameter int PLANE_SZ_W = $clog2(MAX_PLANES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sts_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [SIDE_SZ_W-1:0]          o_width,
    output logic [SIDE_SZ_W-1:0]          o_height,
    output logic [sts_pkg::START_W-1:0]   o_start_col,
    output logic [SIDE_SZ_W-1:0]          o_step_col,
    output logic [sts_pkg::START_W-1:0]   o_start_row,
    output logic [SIDE_SZ_W-1:0]          o_step_row,
    output logic [sts_pkg::START_W-1:0]   o_start_chan,
    output logic [PLANE_SZ_W-1:0]         o_step_chan
);
    import sts_pkg::*;

    localparam int CMP_W = max3(CFG_W, SIDE_SZ_W, PLANE_SZ_W);

    logic [CFG_W-1:0]   r_in_width, r_in_height, r_step_col, r_step_row, r_step_chan;
    logic [START_W-1:0] r_start_col, r_start_row, r_start_chan;
    logic [CMP_W-1:0]   n_width, n_height, n_step_col, n_step_row, n_step_chan;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [CMP_W-1:0] clamp(input logic [CFG_W-1:0] v,
                                               input logic [CMP_W-1:0] lim);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (v == '0) begin
            return CMP_W'(1);
        end else if (ve > lim) begin
            return lim;
        end
        return ve;
    endfunction

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= CFG_W'(1);
            r_in_height  <= CFG_W'(1);
            r_start_col  <= '0;
            r_step_col   <= CFG_W'(1);
            r_start_row  <= '0;
            r_step_row   <= CFG_W'(1);
            r_start_chan <= '0;
            r_step_chan  <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_IN_WIDTH:   r_in_width   <= i_cfg_data;
                REG_IN_HEIGHT:  r_in_height  <= i_cfg_data;
                REG_START_COL:  r_start_col  <= i_cfg_data[START_W-1:0];
                REG_STEP_COL:   r_step_col   <= i_cfg_data;
                REG_START_ROW:  r_start_row  <= i_cfg_data[START_W-1:0];
                REG_STEP_ROW:   r_step_row   <= i_cfg_data;
                REG_START_CHAN: r_start_chan <= i_cfg_data[START_W-1:0];
                REG_STEP_CHAN:  r_step_chan  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // limited values
    always_comb begin
        n_width     = clamp(r_in_width,  CMP_W'(MAX_SIDE));
        n_height    = clamp(r_in_height, CMP_W'(MAX_SIDE));
        n_step_col  = clamp(r_step_col,  CMP_W'(MAX_SIDE));
        n_step_row  = clamp(r_step_row,  CMP_W'(MAX_SIDE));
        n_step_chan = clamp(r_step_chan, CMP_W'(MAX_PLANES));
    end

    assign o_width      = n_width[SIDE_SZ_W-1:0];
    assign o_height     = n_height[SIDE_SZ_W-1:0];
    assign o_step_col   = n_step_col[SIDE_SZ_W-1:0];
    assign o_step_row   = n_step_row[SIDE_SZ_W-1:0];
    assign o_step_chan  = n_step_chan[PLANE_SZ_W-1:0];
    assign o_start_col  = r_start_col;
    assign o_start_row  = r_start_row;
    assign o_start_chan = r_start_chan;

endmodule

[rtl/core/sts_axis.sv]
// ----------------------------------------------------------------------------
// sts_axis
// position, step phase and sliced index counters of one tensor axis
// ----------------------------------------------------------------------------
module sts_axis #(
    parameter int POS_W = 12,
    parameter int SZ_W  = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sts_pkg::t_axis_ctl          i_ctl,
    input  logic [sts_pkg::START_W-1:0] i_start,
    input  logic [SZ_W-1:0]             i_step,
    input  logic [SZ_W-1:0]             i_size,
    output logic                        o_keep,
    output logic                        o_at_end,
    output logic [sts_pkg::IDX_W-1:0]   o_idx
);
    import sts_pkg::*;

    localparam int CW = max3(POS_W + 1, SZ_W, START_W);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CW-1:0]    pos_inc, phase_inc;
    logic             before_start;

    // keep decision and end-of-axis test
    always_comb begin
        pos_inc      = CW'(r_pos) + CW'(1);
        phase_inc    = CW'(r_phase) + CW'(1);
        before_start = CW'(r_pos) < CW'(i_start);
        o_keep       = !before_start && (r_phase == '0);
        o_at_end     = pos_inc >= CW'(i_size);
    end

    // counter update
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_idx   = r_idx;
        if (i_ctl.clr || (i_ctl.en && i_ctl.wrap)) begin
            n_pos   = '0;
            n_phase = '0;
            n_idx   = '0;
        end else if (i_ctl.en) begin
            n_pos = pos_inc[POS_W-1:0];
            if (o_keep) begin
                n_idx = r_idx + IDX_W'(1);
            end
            if (before_start || phase_inc >= CW'(i_step)) begin
                n_phase = '0;
            end else begin
                n_phase = phase_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
            r_idx   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

[rtl/core/sts_out.sv]
// ----------------------------------------------------------------------------
// sts_out
// result register on the master side of the stream
// ----------------------------------------------------------------------------
module sts_out #(
    parameter int OUT_W = 72
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [OUT_W-1:0] i_data,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_space
);
    logic             r_valid, n_valid;
    logic [OUT_W-1:0] r_data;

    // room for a word when empty or when the held word leaves now
    assign o_space = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

[rtl/core/strided_tensor_slice.sv]
// a kept word is registered and appears on the master side in the cycle after it is accepted
// throughput: one word per cycle; the axis counters update in the accepting cycle
// a dropped word is taken in and gives nothing; input stalls only on a full result register
// reset (synchronous, active low) clears the counters, empties the result register
// and returns the configuration to its defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
// strided_tensor_slice
// streaming strided slice of a channel-height-width tensor
// ----------------------------------------------------------------------------
module strided_tensor_slice #(
    parameter int MAX_SIDE    = sts_pkg::MAX_SIDE_DEF,
    parameter int MAX_PLANES  = sts_pkg::MAX_PLANES_DEF,
    parameter int DATA_BITS   = sts_pkg::DATA_BITS_DEF,
    parameter int IN_TDATA_W  = sts_pkg::byte_round(DATA_BITS),
    parameter int OUT_TDATA_W = sts_pkg::byte_round(DATA_BITS + 3 * sts_pkg::IDX_W)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sts_pkg::CFG_W-1:0]     i_cfg_data,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [IN_TDATA_W-1:0]         i_s_tdata,   // value
    input  logic                          i_s_tlast,   // frame_last
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [OUT_TDATA_W-1:0]        o_m_tdata    // kept_value, out_chan, out_row, out_col
);
    import sts_pkg::*;

    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int CPOS_W     = $clog2(MAX_PLANES);
    localparam int SIDE_SZ_W  = $clog2(MAX_SIDE + 1);
    localparam int PLANE_SZ_W = $clog2(MAX_PLANES + 1);

    logic [SIDE_SZ_W-1:0]  width, height, step_col, step_row;
    logic [PLANE_SZ_W-1:0] step_chan;
    logic [START_W-1:0]    start_col, start_row, start_chan;

    logic             accept, row_end, plane_end, frame_end;
    logic             keep_col, keep_row, keep_chan;
    logic             end_col, end_row, end_chan;
    logic [IDX_W-1:0] idx_col, idx_row, idx_chan;
    t_axis_ctl        ctl_col, ctl_row, ctl_chan;
    logic [OUT_TDATA_W-1:0] n_out;

    sts_cfg #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_PLANES (MAX_PLANES),
        .SIDE_SZ_W  (SIDE_SZ_W),
        .PLANE_SZ_W (PLANE_SZ_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_width      (width),
        .o_height     (height),
        .o_start_col  (start_col),
        .o_step_col   (step_col),
        .o_start_row  (start_row),
        .o_step_row   (step_row),
        .o_start_chan (start_chan),
        .o_step_chan  (step_chan)
    );

    // axis sequencing: column fastest, then row, then plane
    always_comb begin
        accept    = i_s_tvalid && o_s_tready;
        row_end   = end_col;
        plane_end = row_end && end_row;
        frame_end = accept && (i_s_tlast || (plane_end && end_chan));

        ctl_col.en    = accept;
        ctl_col.wrap  = row_end;
        ctl_col.clr   = frame_end;
        ctl_row.en    = accept && row_end;
        ctl_row.wrap  = plane_end;
        ctl_row.clr   = frame_end;
        ctl_chan.en   = accept && plane_end;
        ctl_chan.wrap = 1'b0;
        ctl_chan.clr  = frame_end;
    end

    sts_axis #(.POS_W(POS_W), .SZ_W(SIDE_SZ_W)) u_col (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_col),
        .i_start  (start_col),
        .i_step   (step_col),
        .i_size   (width),
        .o_keep   (keep_col),
        .o_at_end (end_col),
        .o_idx    (idx_col)
    );

    sts_axis #(.POS_W(POS_W), .SZ_W(SIDE_SZ_W)) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_row),
        .i_start  (start_row),
        .i_step   (step_row),
        .i_size   (height),
        .o_keep   (keep_row),
        .o_at_end (end_row),
        .o_idx    (idx_row)
    );

    sts_axis #(.POS_W(CPOS_W), .SZ_W(PLANE_SZ_W)) u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_chan),
        .i_start  (start_chan),
        .i_step   (step_chan),
        .i_size   (PLANE_SZ_W'(MAX_PLANES)),
        .o_keep   (keep_chan),
        .o_at_end (end_chan),
        .o_idx    (idx_chan)
    );

    // result word, zero padded to whole bytes
    assign n_out = OUT_TDATA_W'({idx_col, idx_row, idx_chan, i_s_tdata[DATA_BITS-1:0]});

    sts_out #(.OUT_W(OUT_TDATA_W)) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && keep_col && keep_row && keep_chan),
        .i_data     (n_out),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_space    (o_s_tready)
    );

endmodule

[rtl/core/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks of the strided tensor slice, bound to the top level
// ----------------------------------------------------------------------------
module sts_checker #(
    parameter int IN_TDATA_W  = 32,
    parameter int OUT_TDATA_W = 72
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [sts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [sts_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [IN_TDATA_W-1:0]         i_s_tdata,
    input logic                          i_s_tlast,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [OUT_TDATA_W-1:0]        o_m_tdata
);
`include "strided_tensor_slice_assert.svh"

    // a stalled result word holds
    `STS_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result word changed while stalled")

    // the input side only waits on a full, stalled result register
    `STS_ASSERT(a_ready_cause, !o_s_tready |-> o_m_tvalid && !i_m_tready, "input stalled without a stalled result")

    // a new result word only follows an accepted input word
    `STS_ASSERT(a_out_source, $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready), "result word without an accepted input word")

    // reset empties the result register
    `STS_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "result word present after reset")

endmodule

bind strided_tensor_slice sts_checker #(
    .IN_TDATA_W  (IN_TDATA_W),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_sts_checker (.*);

[test/strided_tensor_slice_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_tensor_slice_checker
// follows register writes and accepted slave words, predicts the sliced
// stream and compares every word leaving the master side field by field
// ----------------------------------------------------------------------------
module strided_tensor_slice_checker
    import sts_pkg::*;
#(
    parameter int IN_W  = byte_round(DATA_BITS_DEF),
    parameter int OUT_W = byte_round(DATA_BITS_DEF + 3 * IDX_W)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [IN_W-1:0]      i_s_tdata,   // value
    input  logic                 i_s_tlast,   // frame_last
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OUT_W-1:0]     i_m_tdata,   // kept_value, out_chan, out_row, out_col
    output int                   o_errors,
    output int                   o_pending
);

    localparam int unsigned SIDE_LIMIT  = MAX_SIDE_DEF;
    localparam int unsigned PLANE_LIMIT = MAX_PLANES_DEF;
    localparam int          VAL_W       = DATA_BITS_DEF;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] chan;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } slice_word_t;

    // words still owed by the block, oldest first
    slice_word_t sliced_words_due[$];
    int mismatch_count = 0;

    // shadow copy of the configuration
    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [CFG_W-1:0]   col_step_reg, row_step_reg, chan_step_reg;
    logic [START_W-1:0] col_start_reg, row_start_reg, chan_start_reg;

    // position, distance past the last kept position, next sliced index
    int unsigned col_at, row_at, chan_at;
    int unsigned col_gap, row_gap, chan_gap;
    int unsigned col_next, row_next, chan_next;

    assign o_errors = mismatch_count;

    // zero acts as one, anything past the limit as the limit
    function automatic int unsigned eff_limit(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v == '0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned advance_gap(input int unsigned pos,
                                                input int unsigned start,
                                                input int unsigned gap,
                                                input int unsigned step);
        if (pos < start)
            return 0;
        return (gap + 1 >= step) ? 0 : gap + 1;
    endfunction

    task automatic restart_counts();
        col_at = 0;   row_at = 0;   chan_at = 0;
        col_gap = 0;  row_gap = 0;  chan_gap = 0;
        col_next = 0; row_next = 0; chan_next = 0;
    endtask

    task automatic store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        case (t_reg_idx'(idx))
            REG_IN_WIDTH:   width_reg      = v;
            REG_IN_HEIGHT:  height_reg     = v;
            REG_START_COL:  col_start_reg  = v[START_W-1:0];
            REG_STEP_COL:   col_step_reg   = v;
            REG_START_ROW:  row_start_reg  = v[START_W-1:0];
            REG_STEP_ROW:   row_step_reg   = v;
            REG_START_CHAN: chan_start_reg = v[START_W-1:0];
            REG_STEP_CHAN:  chan_step_reg  = v;
            default: ;
        endcase
    endtask

    // one accepted slave word: queue the kept word, then move the counters on
    task automatic slice_word(input logic [VAL_W-1:0] word, input logic last);
        int unsigned w, h, sc, sr, sp;
        logic        kc, kr, kp, row_end, plane_end;
        slice_word_t hit;
        w  = eff_limit(width_reg, SIDE_LIMIT);
        h  = eff_limit(height_reg, SIDE_LIMIT);
        sc = eff_limit(col_step_reg, SIDE_LIMIT);
        sr = eff_limit(row_step_reg, SIDE_LIMIT);
        sp = eff_limit(chan_step_reg, PLANE_LIMIT);
        kc = (col_at >= col_start_reg) && (col_gap == 0);
        kr = (row_at >= row_start_reg) && (row_gap == 0);
        kp = (chan_at >= chan_start_reg) && (chan_gap == 0);
        row_end   = (col_at + 1 >= w);
        plane_end = row_end && (row_at + 1 >= h);

        if (kc && kr && kp) begin
            hit.value = word;
            hit.chan  = chan_next[IDX_W-1:0];
            hit.row   = row_next[IDX_W-1:0];
            hit.col   = col_next[IDX_W-1:0];
            sliced_words_due.push_back(hit);
        end

        // end of tensor, by flag or by running out of planes
        if (last || (plane_end && chan_at + 1 >= PLANE_LIMIT)) begin
            restart_counts();
            return;
        end

        if (kc)
            col_next++;
        col_gap = advance_gap(col_at, col_start_reg, col_gap, sc);
        col_at++;

        if (row_end) begin
            col_at = 0;
            col_gap = 0;
            col_next = 0;
            if (kr)
                row_next++;
            row_gap = advance_gap(row_at, row_start_reg, row_gap, sr);
            row_at++;
            if (plane_end) begin
                row_at = 0;
                row_gap = 0;
                row_next = 0;
                if (kp)
                    chan_next++;
                chan_gap = advance_gap(chan_at, chan_start_reg, chan_gap, sp);
                chan_at++;
            end
        end
    endtask

    // one accepted master word against the oldest expectation
    task automatic check_word(input logic [OUT_W-1:0] bus);
        slice_word_t got, want;
        got.value = bus[VAL_W-1:0];
        got.chan  = bus[VAL_W +: IDX_W];
        got.row   = bus[VAL_W + IDX_W +: IDX_W];
        got.col   = bus[VAL_W + 2 * IDX_W +: IDX_W];
        if (sliced_words_due.size() == 0) begin
            $error("word with nothing expected: tdata %h", bus);
            mismatch_count++;
            return;
        end
        want = sliced_words_due.pop_front();
        if (got.value !== want.value) begin
            $error("kept_value expected %h actual %h", want.value, got.value);
            mismatch_count++;
        end
        if (got.chan !== want.chan) begin
            $error("out_chan expected %0d actual %0d", want.chan, got.chan);
            mismatch_count++;
        end
        if (got.row !== want.row) begin
            $error("out_row expected %0d actual %0d", want.row, got.row);
            mismatch_count++;
        end
        if (got.col !== want.col) begin
            $error("out_col expected %0d actual %0d", want.col, got.col);
            mismatch_count++;
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg      = 1;
            height_reg     = 1;
            col_step_reg   = 1;
            row_step_reg   = 1;
            chan_step_reg  = 1;
            col_start_reg  = '0;
            row_start_reg  = '0;
            chan_start_reg = '0;
            restart_counts();
            sliced_words_due.delete();
        end else begin
            if (i_cfg_we)
                store_reg(i_cfg_idx, i_cfg_data);
            if (i_m_tvalid && i_m_tready)
                check_word(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                slice_word(i_s_tdata[VAL_W-1:0], i_s_tlast);
        end
        o_pending = sliced_words_due.size();
    end

endmodule

[test/tb_strided_tensor_slice.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_tensor_slice
// drives configuration shapes and tensor streams with random gaps on both
// sides; a checker beside the block predicts and compares every kept word
// ----------------------------------------------------------------------------
module tb_strided_tensor_slice;
    import sts_pkg::*;

    localparam int IN_W        = byte_round(DATA_BITS_DEF);
    localparam int OUT_W       = byte_round(DATA_BITS_DEF + 3 * IDX_W);
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_WORDS  = 1350;
    localparam int GAP_PCT     = 37;
    localparam int FRAME_CAP   = 300;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_we   = 1'b0;
    t_reg_idx         cfg_idx  = REG_IN_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               errors;
    int               pending;
    bit               calm = 1'b0;
    int unsigned      words_sent = 0;
    int unsigned      cycles = 0;
    int unsigned      rand_base;
    int               phase_no;

    strided_tensor_slice dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    strided_tensor_slice_checker checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // master side backpressure
    always @(negedge clk) begin
        m_tready <= calm || ($urandom_range(99) >= GAP_PCT);
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_strided_tensor_slice: errors");
            $finish;
        end
    end

    // wait until every kept word is out and the block has gone quiet
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_shape(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] col_start,
                              input logic [CFG_W-1:0] col_step,
                              input logic [CFG_W-1:0] row_start,
                              input logic [CFG_W-1:0] row_step,
                              input logic [CFG_W-1:0] chan_start,
                              input logic [CFG_W-1:0] chan_step);
        settle();
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_START_COL, col_start);
        write_reg(REG_STEP_COL, col_step);
        write_reg(REG_START_ROW, row_start);
        write_reg(REG_STEP_ROW, row_step);
        write_reg(REG_START_CHAN, chan_start);
        write_reg(REG_STEP_CHAN, chan_step);
    endtask

    // one slave word, with a random gap ahead of it
    task automatic send_word(input logic [IN_W-1:0] v, input logic last);
        while (!calm && $urandom_range(99) < GAP_PCT) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input int unsigned n, input bit with_last);
        for (int unsigned i = 0; i < n; i++)
            send_word($urandom(), with_last && (i == n - 1));
    endtask

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        return (v > MAX_SIDE_DEF) ? MAX_SIDE_DEF : 32'(v);
    endfunction

    // mostly small sizes, some zero, a few past the limit
    function automatic logic [CFG_W-1:0] pick_size(input int unsigned small_hi);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return CFG_W'($urandom_range(small_hi, 1));
        if (r < 80)
            return '0;
        if (r < 96)
            return CFG_W'($urandom_range(40, small_hi + 1));
        return CFG_W'($urandom_range(8191, MAX_SIDE_DEF + 1));
    endfunction

    function automatic logic [CFG_W-1:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return CFG_W'($urandom_range(4, 1));
        if (r < 85)
            return '0;
        if (r < 95)
            return CFG_W'($urandom_range(12, 5));
        return CFG_W'($urandom_range(8191, MAX_SIDE_DEF));
    endfunction

    // mostly inside the axis, sometimes just past its end, sometimes anywhere
    function automatic logic [CFG_W-1:0] pick_start(input int unsigned span);
        int          r;
        int unsigned top;
        r   = $urandom_range(99);
        top = (span > MAX_SIDE_DEF - 1) ? MAX_SIDE_DEF - 1 : span;
        if (r < 80)
            return CFG_W'($urandom_range(top - 1, 0));
        if (r < 90)
            return CFG_W'($urandom_range((top + 2 > 4095) ? 4095 : top + 2, top));
        return CFG_W'($urandom_range(4095, 0));
    endfunction

    // random shape, then a few tensors: mostly whole, some cut short or run on
    task automatic random_phase();
        logic [CFG_W-1:0] w, h;
        int unsigned      planes, total, n, frames;
        int               r;
        w      = pick_size(6);
        h      = pick_size(4);
        planes = $urandom_range(5, 1);
        load_shape(w, h, pick_start(eff_dim(w)), pick_step(), pick_start(eff_dim(h)),
                   pick_step(), pick_start(planes), pick_step());
        total  = eff_dim(w) * eff_dim(h) * planes;
        frames = $urandom_range(4, 1);
        for (int f = 0; f < frames; f++) begin
            r = $urandom_range(99);
            if (total > FRAME_CAP)
                send_run($urandom_range(FRAME_CAP, 1), 1'b1);
            else if (r < 78)
                send_run(total, 1'b1);
            else if (r < 89)
                send_run($urandom_range(total, 1), 1'b1);
            else
                send_run(total, 1'b0);
        end
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset shape: every word is its own plane
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hA5A5_5A5A, 1'b1);
        send_word(32'h1234_5678, 1'b1);

        // zero sizes and zero steps, first plane skipped
        load_shape(0, 0, 0, 0, 0, 0, 1, 0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word($urandom(), 1'b1);

        // strided columns, huge row step, flag in the middle of a row
        load_shape(5, 2, 1, 2, 1, 13'd8191, 0, 2);
        send_run(7, 1'b1);

        // column start past the end of the row
        load_shape(3, 1, 5, 1, 0, 1, 0, 1);
        send_run(6, 1'b1);

        // oversize width register, part of a row, no gaps on either side
        load_shape(13'd8191, 1, 0, 1, 0, 1, 0, 1);
        calm = 1'b1;
        send_run(256, 1'b1);
        calm = 1'b0;

        // oversize height register, every fifth row from row three
        load_shape(1, 13'd8191, 0, 1, 3, 5, 0, 1);
        send_run(120, 1'b1);

        // random shapes and tensors
        rand_base = words_sent;
        phase_no  = 0;
        while (words_sent < rand_base + RAND_WORDS) begin
            calm = (phase_no >= 12) && (phase_no < 20);
            random_phase();
            phase_no++;
        end
        calm = 1'b0;

        // drain, then allow time for any stray word
        settle();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("tb_strided_tensor_slice: clean");
        else
            $display("tb_strided_tensor_slice: errors");
        $finish;
    end

endmodule
